>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the task dispatcher.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Concurrent property, checked at every rising edge outside reset.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)
`endif
`endif

>>> rtl/core/ttd_pkg.sv
// Types and constants of the timer table task dispatcher.
// No dependencies; used by the ready queue and the top level.
package ttd_pkg;

  localparam int ID_W     = 8;
  localparam int DELAY_W  = 15;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Operation codes carried in the input item's mode field.
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POST   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TAKE   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

  // One timer slot as held in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [DELAY_W-1:0] period;
    logic [DELAY_W-1:0] remaining;
    logic               persistent;
  } slot_t;

  // Requests to the ready queue.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  // Fill state of the ready queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> rtl/core/ttd_ready_fifo.sv
// Ready queue of task ids: a circular buffer memory with head, tail and count.
// Depends on ttd_pkg for the id width and the control and status structs.
module ttd_ready_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ttd_pkg::fifo_ctl_t     ctl,
  input  logic [ttd_pkg::ID_W-1:0] push_id,
  output ttd_pkg::fifo_stat_t    stat,
  output logic [ttd_pkg::ID_W-1:0] head_id
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [ttd_pkg::ID_W-1:0] store [DEPTH];
  logic [PTR_W-1:0]         head;
  logic [PTR_W-1:0]         tail;
  logic [CNT_W-1:0]         count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // Storage: one write at the tail, the head entry read into a register.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      store[tail] <= push_id;
    end
    head_id <= store[head];
  end

  // Pointers wrap at the last entry, so the depth need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail <= (tail == LAST_PTR) ? '0 : tail + PTR_W'(1);
      end
      if (ctl.pop) begin
        head <= (head == LAST_PTR) ? '0 : head + PTR_W'(1);
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/timer_table_task_dispatcher.sv
// Timer table task dispatcher: timer slots plus a ready queue of task ids.
// Depends on ttd_pkg, ttd_ready_fifo and assert_macros.svh.

// Each input item carries one operation and yields exactly one result item.
// Items are handled one at a time by a small sequencer around a shared slot
// memory port and decrement/compare unit, so s_tready is high only while the
// sequencer is idle. Add timer scans the occupancy bits one slot a cycle
// from the first slot and stops at the first free one or at the last; remove timer
// and tick walk every slot through the registered slot memory read, one slot
// a cycle; post task and the unused mode values go straight to the result,
// and take next first passes through a state for the registered read of the
// queue head, or goes straight to the result when the queue is empty.
// The next item can be accepted from the cycle after the result is loaded.
// A finished result waits in the output register while the next item is taken.
// No clearing pass is needed after reset: slot occupancy is held in flip-flops.
`include "assert_macros.svh"

module timer_table_task_dispatcher #(
  parameter int READY_DEPTH = 16,
  parameter int TIMER_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // task_id [7:0], delay [22:8], persistent [23]
  input  logic [2:0]  s_tuser,   // mode [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // next_task [7:0]
  output logic [1:0]  m_tuser    // status [1:0]
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_TAKE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  // Input item fields.
  logic                             accept;
  logic [ttd_pkg::MODE_W-1:0]       in_mode;
  logic [ttd_pkg::ID_W-1:0]         in_id;
  logic [ttd_pkg::DELAY_W-1:0]      in_delay;
  logic                             in_pers;

  // Operation held for the duration of the item.
  logic [ttd_pkg::MODE_W-1:0]       op_mode;
  logic [ttd_pkg::ID_W-1:0]         op_id;
  logic [ttd_pkg::DELAY_W-1:0]      op_delay;
  logic                             op_pers;

  // Slot walk control.
  logic [SLOT_W-1:0]                walk_idx;
  logic                             issue;
  logic                             proc_valid;
  logic [SLOT_W-1:0]                proc_idx;
  logic [TIMER_SLOTS-1:0]           occ;

  // Slot memory ports.
  ttd_pkg::slot_t                   slot_mem [TIMER_SLOTS];
  ttd_pkg::slot_t                   slot_rdata;
  ttd_pkg::slot_t                   slot_wdata;
  logic                             slot_we;
  logic [SLOT_W-1:0]                slot_waddr;
  logic                             occ_set;
  logic                             occ_clr;
  logic [SLOT_W-1:0]                occ_idx;

  // Ready queue interface.
  ttd_pkg::fifo_ctl_t               fifo_ctl;
  ttd_pkg::fifo_stat_t              fifo_stat;
  logic [ttd_pkg::ID_W-1:0]         push_id;
  logic [ttd_pkg::ID_W-1:0]         head_id;

  // Result waiting to enter the output register.
  logic [ttd_pkg::STATUS_W-1:0]     pend_status;
  logic [ttd_pkg::ID_W-1:0]         pend_next;
  logic [ttd_pkg::STATUS_W-1:0]     pend_status_next;
  logic [ttd_pkg::ID_W-1:0]         pend_next_next;
  logic                             out_free;
  logic                             proc_last;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_mode   = s_tuser;
  assign in_id     = s_tdata[7:0];
  assign in_delay  = s_tdata[22:8];
  assign in_pers   = s_tdata[23];
  assign out_free  = !m_tvalid || m_tready;
  assign proc_last = proc_valid && (proc_idx == LAST_SLOT);

  ttd_ready_fifo #(
    .DEPTH (READY_DEPTH)
  ) u_ready (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fifo_ctl),
    .push_id (push_id),
    .stat    (fifo_stat),
    .head_id (head_id)
  );

  // Slot memory: one write per cycle, read at the walk index into a register.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[walk_idx];
  end

  // Per-slot work: first-free search for add, match for remove, count for tick; queue push for post, pop for take.
  always_comb begin
    slot_we      = 1'b0;
    slot_waddr   = walk_idx;
    slot_wdata   = slot_rdata;
    occ_set      = 1'b0;
    occ_clr      = 1'b0;
    occ_idx      = walk_idx;
    fifo_ctl     = '0;
    push_id      = slot_rdata.task_id;
    unique case (state)
      S_IDLE: begin
        if (accept && (in_mode == ttd_pkg::MODE_POST) && !fifo_stat.full) begin
          fifo_ctl.push = 1'b1;
          push_id       = in_id;
        end
      end
      S_ADD: begin
        if (!occ[walk_idx]) begin
          slot_we               = 1'b1;
          slot_wdata.task_id    = op_id;
          slot_wdata.period     = op_delay;
          slot_wdata.remaining  = op_delay;
          slot_wdata.persistent = op_pers;
          occ_set               = (op_id != '0);
        end
      end
      S_WALK: begin
        occ_idx    = proc_idx;
        slot_waddr = proc_idx;
        if (proc_valid && occ[proc_idx]) begin
          if (op_mode == ttd_pkg::MODE_REMOVE) begin
            occ_clr = (slot_rdata.task_id == op_id);
          end else if (slot_rdata.remaining != '0) begin
            slot_we              = 1'b1;
            slot_wdata.remaining = slot_rdata.remaining - ttd_pkg::DELAY_W'(1);
          end else begin
            fifo_ctl.push = !fifo_stat.full;
            if (slot_rdata.persistent) begin
              slot_we              = 1'b1;
              slot_wdata.remaining = slot_rdata.period;
            end else begin
              occ_clr = 1'b1;
            end
          end
        end
      end
      S_TAKE: begin
        fifo_ctl.pop = 1'b1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Slot occupancy bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (occ_set) begin
      occ[occ_idx] <= 1'b1;
    end else if (occ_clr) begin
      occ[occ_idx] <= 1'b0;
    end
  end

  // Result of the current operation, decided where each operation finishes.
  always_comb begin
    pend_status_next = pend_status;
    pend_next_next   = pend_next;
    unique case (state)
      S_IDLE: begin
        pend_status_next = ttd_pkg::STATUS_OK;
        pend_next_next   = '0;
        if (in_mode == ttd_pkg::MODE_POST && fifo_stat.full) begin
          pend_status_next = ttd_pkg::STATUS_OVERFLOW;
        end else if (in_mode == ttd_pkg::MODE_TAKE && fifo_stat.empty) begin
          pend_status_next = ttd_pkg::STATUS_EMPTY;
        end
      end
      S_ADD: begin
        if (occ[walk_idx] && (walk_idx == LAST_SLOT)) begin
          pend_status_next = ttd_pkg::STATUS_OVERFLOW;
        end
      end
      S_TAKE: begin
        pend_next_next = head_id;
      end
      default: begin
      end
    endcase
  end

  // Operation and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= in_mode;
      op_id    <= in_id;
      op_delay <= in_delay;
      op_pers  <= in_pers;
    end
    if (accept || state != S_IDLE) begin
      pend_status <= pend_status_next;
      pend_next   <= pend_next_next;
    end
    proc_idx <= walk_idx;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk_idx   <= '0;
      issue      <= 1'b0;
      proc_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          walk_idx   <= '0;
          proc_valid <= 1'b0;
          issue      <= 1'b0;
          if (accept) begin
            unique case (in_mode) inside
              ttd_pkg::MODE_ADD: begin
                state <= S_ADD;
              end
              ttd_pkg::MODE_REMOVE, ttd_pkg::MODE_TICK: begin
                state <= S_WALK;
                issue <= 1'b1;
              end
              ttd_pkg::MODE_TAKE: begin
                state <= fifo_stat.empty ? S_DONE : S_TAKE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_ADD: begin
          if (!occ[walk_idx] || walk_idx == LAST_SLOT) begin
            state <= S_DONE;
          end else begin
            walk_idx <= walk_idx + SLOT_W'(1);
          end
        end
        S_WALK: begin
          proc_valid <= issue;
          if (issue) begin
            if (walk_idx == LAST_SLOT) begin
              issue <= 1'b0;
            end else begin
              walk_idx <= walk_idx + SLOT_W'(1);
            end
          end
          if (proc_last) begin
            state      <= S_DONE;
            proc_valid <= 1'b0;
          end
        end
        S_TAKE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded from the finished operation, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tuser <= pend_status;
      m_tdata <= pend_next;
    end
  end

  // Checks on the sequencer, the ready queue handshake and the result payload.
  `ASSERT_NEVER(a_push_full, clk, rst, fifo_ctl.push && fifo_stat.full, "push into a full ready queue")
  `ASSERT_NEVER(a_pop_empty, clk, rst, fifo_ctl.pop && fifo_stat.empty, "pop from an empty ready queue")
  `ASSERT_PROP(a_walk_state, clk, rst, proc_valid |-> (state == S_WALK), "slot processed outside a walk")
  `ASSERT_PROP(a_next_ok, clk, rst, (m_tvalid && m_tuser != ttd_pkg::STATUS_OK) |-> (m_tdata == '0), "task id given with a failure status")

endmodule

>>> tb/sv/ttd_dispatch_checker.sv
// Checker for the timer table task dispatcher: watches both item channels,
// predicts each result from its own copy of the slot table and ready queue.
// Depends on ttd_pkg for widths, operation codes and status codes.
`timescale 1ns / 1ps

module ttd_dispatch_checker #(
  parameter int READY_DEPTH = 16,
  parameter int TIMER_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // task_id [7:0], delay [22:8], persistent [23]
  input  logic [2:0]  s_tuser,   // mode [2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // next_task [7:0]
  input  logic [1:0]  m_tuser,   // status [1:0]
  output int          fail_count,
  output int          outstanding,
  output int          results_seen,
  output int          table_full_hits,
  output int          queue_full_hits,
  output int          empty_takes,
  output int          timers_fired
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [ttd_pkg::STATUS_W-1:0] status;
    logic [ttd_pkg::ID_W-1:0]     next_task;
  } dispatch_result_t;

  // Shadow copy of the ready queue.
  logic [ttd_pkg::ID_W-1:0]    ready_ids [READY_DEPTH];
  int                          q_head;
  int                          q_tail;
  int                          q_fill;

  // Shadow copy of the timer slots; id zero marks a free slot.
  logic [ttd_pkg::ID_W-1:0]    timer_id     [TIMER_SLOTS];
  logic [ttd_pkg::DELAY_W-1:0] timer_period [TIMER_SLOTS];
  logic [ttd_pkg::DELAY_W-1:0] timer_left   [TIMER_SLOTS];
  logic                        timer_keep   [TIMER_SLOTS];

  dispatch_result_t   pending_results [$];

  // Prints one line for the first few mismatches and counts every one.
  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < MAX_REPORTS)
      $display("mismatch at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Appends an id to the shadow queue; refuses when the queue is full.
  function automatic bit enqueue_id(logic [ttd_pkg::ID_W-1:0] id);
    if (q_fill >= READY_DEPTH) return 1'b0;
    ready_ids[q_tail] = id;
    q_tail = (q_tail + 1) % READY_DEPTH;
    q_fill++;
    return 1'b1;
  endfunction

  // Applies one operation to the shadow state and returns the result it yields.
  function automatic dispatch_result_t apply_operation(
      logic [ttd_pkg::MODE_W-1:0]  mode,
      logic [ttd_pkg::ID_W-1:0]    id,
      logic [ttd_pkg::DELAY_W-1:0] delay,
      logic                        keep);
    dispatch_result_t res;
    int               free_slot;
    res.status    = ttd_pkg::STATUS_OK;
    res.next_task = '0;
    free_slot     = -1;
    case (mode)
      ttd_pkg::MODE_ADD: begin
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
          if (timer_id[i] == '0) free_slot = i;
        if (free_slot < 0) begin
          res.status = ttd_pkg::STATUS_OVERFLOW;
          table_full_hits++;
        end else begin
          // An id of zero lands in the slot and so leaves it free.
          timer_id[free_slot]     = id;
          timer_period[free_slot] = delay;
          timer_left[free_slot]   = delay;
          timer_keep[free_slot]   = keep;
        end
      end
      ttd_pkg::MODE_REMOVE: begin
        for (int i = 0; i < TIMER_SLOTS; i++)
          if (timer_id[i] == id) timer_id[i] = '0;
      end
      ttd_pkg::MODE_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (timer_id[i] != '0) begin
            if (timer_left[i] != '0) begin
              timer_left[i] = timer_left[i] - 1'b1;
            end else begin
              // A firing on a full queue is dropped without a trace.
              void'(enqueue_id(timer_id[i]));
              timers_fired++;
              if (timer_keep[i]) timer_left[i] = timer_period[i];
              else timer_id[i] = '0;
            end
          end
        end
      end
      ttd_pkg::MODE_POST: begin
        if (!enqueue_id(id)) begin
          res.status = ttd_pkg::STATUS_OVERFLOW;
          queue_full_hits++;
        end
      end
      ttd_pkg::MODE_TAKE: begin
        if (q_fill == 0) begin
          res.status = ttd_pkg::STATUS_EMPTY;
          empty_takes++;
        end else begin
          res.next_task = ready_ids[q_head];
          q_head = (q_head + 1) % READY_DEPTH;
          q_fill--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Results are compared before the item accepted on the same edge is added,
  // since a result can never belong to an item taken at that very edge.
  always @(posedge clk) begin : scoreboard
    dispatch_result_t want;
    if (rst) begin
      q_head          = 0;
      q_tail          = 0;
      q_fill          = 0;
      fail_count      = 0;
      results_seen    = 0;
      table_full_hits = 0;
      queue_full_hits = 0;
      empty_takes     = 0;
      timers_fired    = 0;
      for (int i = 0; i < TIMER_SLOTS; i++) timer_id[i] = '0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result item with nothing outstanding", m_tdata, -1);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.status)
            report_mismatch("status", m_tuser, want.status);
          if (m_tdata !== want.next_task)
            report_mismatch("next_task", m_tdata, want.next_task);
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(
          apply_operation(s_tuser[ttd_pkg::MODE_W-1:0],
                          s_tdata[ttd_pkg::ID_W-1:0],
                          s_tdata[ttd_pkg::ID_W +: ttd_pkg::DELAY_W],
                          s_tdata[ttd_pkg::ID_W+ttd_pkg::DELAY_W]));
    end
    outstanding <= pending_results.size();
  end

endmodule

>>> tb/sv/tb.sv
// Top of the dispatcher testbench: clock, reset, item stimulus, receiver
// back-pressure and the verdict. Depends on ttd_pkg, the dispatcher and the checker.
`timescale 1ns / 1ps

module tb;

  localparam int READY_DEPTH  = 16;
  localparam int TIMER_SLOTS  = 8;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_LEN    = 150;
  localparam int DRAIN_CYCLES = 4 * (TIMER_SLOTS + 2);
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;

  int fail_count;
  int outstanding;
  int results_seen;
  int table_full_hits;
  int queue_full_hits;
  int empty_takes;
  int timers_fired;
  int items_sent = 0;
  int sender_burst = 0;

  // Receiver bookkeeping.
  int rx_cycle  = 0;
  int rx_hold   = 0;
  int rx_smooth = 0;
  int rx_stall  = 0;
  int rx_pick;

  timer_table_task_dispatcher #(
    .READY_DEPTH(READY_DEPTH),
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ttd_dispatch_checker #(
    .READY_DEPTH(READY_DEPTH),
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .table_full_hits (table_full_hits),
    .queue_full_hits (queue_full_hits),
    .empty_takes     (empty_takes),
    .timers_fired    (timers_fired)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, occasional stretches with none, and a long
  // hold-off now and then so that the output register fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 8000 == 3000) rx_hold = $urandom_range(300, 500);
      if (rx_cycle % 5000 == 0) rx_smooth = 400;
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_smooth > 0) begin
        rx_smooth--;
        m_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 20) begin
          rx_stall = (rx_pick < 2) ? $urandom_range(10, 60) : $urandom_range(0, 2);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
             outstanding);
    $display("FAIL timer_table_task_dispatcher");
    $finish;
  end

  // Offers one item after a random gap and returns once it has been accepted.
  task automatic send_item(logic [ttd_pkg::MODE_W-1:0] mode,
                           logic [ttd_pkg::ID_W-1:0] id,
                           logic [ttd_pkg::DELAY_W-1:0] delay, logic keep);
    int gap;
    int pick;
    if (sender_burst > 0) begin
      sender_burst--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        sender_burst = $urandom_range(20, 60);
        gap = 0;
      end else if (pick < 50) begin
        gap = 0;
      end else if (pick < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(10, 60);
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {keep, delay, id};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [ttd_pkg::MODE_W-1:0]  mode;
    logic [ttd_pkg::ID_W-1:0]    id;
    logic [ttd_pkg::DELAY_W-1:0] delay;
    int                          pick;
    int                          add_t;
    int                          rem_t;
    int                          tick_t;
    int                          post_t;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty take, zero ids, extreme delays, firing and reload,
    // unused codes, a full table and removal.
    send_item(ttd_pkg::MODE_TAKE,   8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_POST,   8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_TAKE,   8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_POST,   8'd255, 15'h7fff,  1'b1);
    send_item(ttd_pkg::MODE_TAKE,   8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_ADD,    8'd255, 15'h7fff,  1'b1);
    send_item(ttd_pkg::MODE_ADD,    8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_REMOVE, 8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_REMOVE, 8'd99,  15'd0,     1'b0);
    send_item(ttd_pkg::MODE_ADD,    8'd1,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_ADD,    8'd2,   15'd1,     1'b1);
    send_item(ttd_pkg::MODE_TICK,   8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_TICK,   8'd0,   15'd0,     1'b0);
    send_item(3'd5,                 8'hff,  15'h7fff,  1'b1);
    send_item(3'd6,                 8'h5a,  15'h2aaa,  1'b0);
    send_item(3'd7,                 8'ha5,  15'h5555,  1'b1);
    for (int i = 3; i <= 8; i++)
      send_item(ttd_pkg::MODE_ADD, ttd_pkg::ID_W'(i), 15'd2, i[0]);
    send_item(ttd_pkg::MODE_ADD,    8'd9,   15'd3,     1'b0);
    send_item(ttd_pkg::MODE_REMOVE, 8'd255, 15'd0,     1'b0);
    send_item(ttd_pkg::MODE_TAKE,   8'd0,   15'd0,     1'b0);
    send_item(ttd_pkg::MODE_TAKE,   8'd0,   15'd0,     1'b0);

    // Random part in phases that favour filling the table, filling the
    // queue, draining it, or a balanced mix.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / PHASE_LEN) % 4)
        0: begin add_t = 20; rem_t = 30; tick_t = 55; post_t = 75; end
        1: begin add_t = 40; rem_t = 45; tick_t = 70; post_t = 80; end
        2: begin add_t = 10; rem_t = 15; tick_t = 30; post_t = 85; end
        default: begin add_t = 10; rem_t = 25; tick_t = 45; post_t = 55; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        mode = ttd_pkg::MODE_W'($urandom_range(5, 7));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < add_t)       mode = ttd_pkg::MODE_ADD;
        else if (pick < rem_t)  mode = ttd_pkg::MODE_REMOVE;
        else if (pick < tick_t) mode = ttd_pkg::MODE_TICK;
        else if (pick < post_t) mode = ttd_pkg::MODE_POST;
        else                    mode = ttd_pkg::MODE_TAKE;
      end
      // Ids mostly from a small pool so that removals find their timers.
      pick = $urandom_range(0, 99);
      if (pick < 60)      id = ttd_pkg::ID_W'($urandom_range(1, 12));
      else if (pick < 70) id = '0;
      else if (pick < 75) id = '1;
      else                id = ttd_pkg::ID_W'($urandom_range(0, 255));
      // Short delays keep timers firing; a few long ones exercise every bit.
      pick = $urandom_range(0, 99);
      if (pick < 70)      delay = ttd_pkg::DELAY_W'($urandom_range(0, 3));
      else if (pick < 90) delay = ttd_pkg::DELAY_W'($urandom_range(4, 20));
      else if (pick < 98) delay = ttd_pkg::DELAY_W'($urandom_range(0, 32767));
      else                delay = '1;
      send_item(mode, id, delay, 1'($urandom_range(0, 1)));
    end
    s_tvalid <= 1'b0;

    // Drain, then allow a few more cycles for any stray result.
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items over all five operations and the unused codes, %0d results.",
             items_sent, results_seen);
    $display("Refused adds %0d, refused posts %0d, empty takes %0d, timer firings %0d.",
             table_full_hits, queue_full_hits, empty_takes, timers_fired);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS timer_table_task_dispatcher");
    end else begin
      $display("FAIL timer_table_task_dispatcher");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ttd_pkg.sv
rtl/core/ttd_ready_fifo.sv
rtl/core/timer_table_task_dispatcher.sv
tb/sv/ttd_dispatch_checker.sv
tb/sv/tb.sv
